@@ rtl/core/acs_pkg.sv @@
// shared types, constants and alphabet mapping functions for the affine cipher
`timescale 1ns / 1ps

package acs_pkg;

   localparam int ALPHABET_SIZE = 66;
   localparam int KEY_W         = 7;
   localparam int BYTE_W        = 8;
   localparam int DATA_W        = 32;
   localparam int ADDR_W        = 4;

   // a*x + b with every term below the alphabet size
   localparam int PROD_W        = 13;

   // floor(p / 66) == (p * 993) >> 16 for every p below 4356
   localparam int RECIP_SHIFT   = 16;
   localparam int RECIP_W       = 23;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(993);

   typedef enum logic [1:0] {
      REG_KEY_MULT     = 2'd0,
      REG_KEY_ADD      = 2'd1,
      REG_KEY_MULT_INV = 2'd2
   } acs_reg_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } acs_op_type;

   typedef struct packed {
      logic [KEY_W-1:0] mult;
      logic [KEY_W-1:0] add;
      logic [KEY_W-1:0] mult_inverse;
   } acs_keys_type;

   typedef struct packed {
      logic             hit;
      logic [KEY_W-1:0] idx;
   } acs_index_type;

   // a 7-bit key is below twice the alphabet size, so one subtract reduces it
   function automatic logic [KEY_W-1:0] key_reduce(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      if (k >= KEY_W'(ALPHABET_SIZE)) begin
         r = k - KEY_W'(ALPHABET_SIZE);
      end else begin
         r = k;
      end
      return r;
   endfunction

   // byte to alphabet position
   function automatic acs_index_type char_to_index(input logic [BYTE_W-1:0] c);
      acs_index_type r;
      r.hit = 1'b1;
      r.idx = '0;
      if (c inside {[8'h61:8'h7a]}) begin
         r.idx = KEY_W'(c - 8'h61);
      end else if (c == 8'h20) begin
         r.idx = KEY_W'(26);
      end else if (c inside {[8'h41:8'h5a]}) begin
         r.idx = KEY_W'(c - 8'h26);
      end else if (c == 8'h2e) begin
         r.idx = KEY_W'(53);
      end else if (c == 8'h2d) begin
         r.idx = KEY_W'(54);
      end else if (c == 8'h5f) begin
         r.idx = KEY_W'(55);
      end else if (c inside {[8'h30:8'h39]}) begin
         r.idx = KEY_W'(c + 8'h08);
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

   // alphabet position to byte
   function automatic logic [BYTE_W-1:0] index_to_char(input logic [KEY_W-1:0] i);
      logic [BYTE_W-1:0] w;
      logic [BYTE_W-1:0] r;
      w = BYTE_W'(i);
      if (i inside {[7'd0:7'd25]}) begin
         r = w + 8'h61;
      end else if (i == 7'd26) begin
         r = 8'h20;
      end else if (i inside {[7'd27:7'd52]}) begin
         r = w + 8'h26;
      end else if (i == 7'd53) begin
         r = 8'h2e;
      end else if (i == 7'd54) begin
         r = 8'h2d;
      end else if (i == 7'd55) begin
         r = 8'h5f;
      end else if (i inside {[7'd56:7'd65]}) begin
         r = w - 8'h08;
      end else begin
         r = 8'h00;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/acs_xform.sv @@
// three-stage cipher pipeline: input register, product register, result register
`timescale 1ns / 1ps

module acs_xform (
   input  logic                         clock,
   input  logic                         reset,
   input  acs_pkg::acs_keys_type        keys,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [acs_pkg::BYTE_W-1:0]   req_char_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [acs_pkg::BYTE_W-1:0]   rsp_char_out,
   output logic                         rsp_invalid
);

   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s0_take, s1_take, s2_take;

   logic                          s0_op_ff;
   logic [acs_pkg::BYTE_W-1:0]    s0_byte_ff;
   logic [acs_pkg::PROD_W-1:0]    s1_prod_ff, s1_prod_in;
   logic                          s1_invalid_ff, s1_invalid_in;
   logic [acs_pkg::BYTE_W-1:0]    s2_char_ff, s2_char_in;
   logic                          s2_invalid_ff;

   acs_pkg::acs_index_type        x;
   logic [acs_pkg::KEY_W-1:0]     add_r, mult_r, inv_r;
   logic [acs_pkg::BYTE_W-1:0]    diff;
   logic [acs_pkg::KEY_W-1:0]     diff_r;
   logic [acs_pkg::KEY_W-1:0]     factor, operand, addend;
   logic [2*acs_pkg::KEY_W-1:0]   prod_full;

   logic [acs_pkg::RECIP_W-1:0]   recip;
   logic [acs_pkg::KEY_W-1:0]     quot;
   logic [acs_pkg::PROD_W-1:0]    quot_x66;
   logic [acs_pkg::KEY_W-1:0]     rem;

   // handshake: each stage moves when the one after it has room
   assign s2_take   = !s2_valid_ff || !rsp_stall;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign s0_take   = !s0_valid_ff || s1_take;
   assign req_stall = !s0_take;

   assign s0_valid_in = s0_take ? req_valid   : s0_valid_ff;
   assign s1_valid_in = s1_take ? s0_valid_ff : s1_valid_ff;
   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage 0: alphabet index, key reduction and the one multiply
   always_comb begin
      x      = acs_pkg::char_to_index(s0_byte_ff);
      add_r  = acs_pkg::key_reduce(keys.add);
      mult_r = acs_pkg::key_reduce(keys.mult);
      inv_r  = acs_pkg::key_reduce(keys.mult_inverse);
      diff   = acs_pkg::BYTE_W'(x.idx) + acs_pkg::BYTE_W'(acs_pkg::ALPHABET_SIZE)
               - acs_pkg::BYTE_W'(add_r);
      if (diff >= acs_pkg::BYTE_W'(acs_pkg::ALPHABET_SIZE)) begin
         diff_r = acs_pkg::KEY_W'(diff - acs_pkg::BYTE_W'(acs_pkg::ALPHABET_SIZE));
      end else begin
         diff_r = acs_pkg::KEY_W'(diff);
      end
      if (s0_op_ff == acs_pkg::OP_DECRYPT) begin
         factor  = inv_r;
         operand = diff_r;
         addend  = '0;
      end else begin
         factor  = mult_r;
         operand = x.idx;
         addend  = add_r;
      end
      prod_full = (2*acs_pkg::KEY_W)'(factor) * (2*acs_pkg::KEY_W)'(operand)
                  + (2*acs_pkg::KEY_W)'(addend);
      s1_prod_in    = acs_pkg::PROD_W'(prod_full);
      s1_invalid_in = !x.hit;
   end

   // stage 1: mod 66 by reciprocal multiply, then back to a byte
   always_comb begin
      recip    = acs_pkg::RECIP_W'(s1_prod_ff) * acs_pkg::RECIP_MUL;
      quot     = recip[acs_pkg::RECIP_SHIFT +: acs_pkg::KEY_W];
      quot_x66 = (acs_pkg::PROD_W'(quot) << 6) + (acs_pkg::PROD_W'(quot) << 1);
      rem      = acs_pkg::KEY_W'(s1_prod_ff - quot_x66);
      if (s1_invalid_ff) begin
         s2_char_in = '0;
      end else begin
         s2_char_in = acs_pkg::index_to_char(rem);
      end
   end

   always_ff @(posedge clock) begin
      if (s0_take && req_valid) begin
         s0_op_ff   <= req_op;
         s0_byte_ff <= req_char_in;
      end
      if (s1_take && s0_valid_ff) begin
         s1_prod_ff    <= s1_prod_in;
         s1_invalid_ff <= s1_invalid_in;
      end
      if (s2_take && s1_valid_ff) begin
         s2_char_ff    <= s2_char_in;
         s2_invalid_ff <= s1_invalid_ff;
      end
   end

   assign rsp_valid    = s2_valid_ff;
   assign rsp_char_out = s2_char_ff;
   assign rsp_invalid  = s2_invalid_ff;

endmodule

@@ rtl/core/affine_cipher_66_symbol.sv @@
// Affine cipher over a 66-symbol alphabet (a-z, space, A-Z, '.', '-', '_', 0-9).
// Each word carries one byte and a direction; encrypt maps index x to (a*x+b) mod 66,
// decrypt to (a_inv*(x-b)) mod 66, and a byte outside the alphabet comes back as 0
// with rsp_invalid set. The pipeline has three register stages (input, product,
// result): a word moves from the input register to the product register and then to
// the result register; with no back-pressure one word can be taken every cycle. A stalled
// result backs the words up, and the input stalls only once all three stages hold one.
// Keys are used mod 66 and are not checked for being coprime. Keys sit at byte
// addresses 0 (a), 4 (b) and 8 (a_inv) and should be written only while no word is
// in flight.
`timescale 1ns / 1ps

module affine_cipher_66_symbol (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [acs_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [acs_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [acs_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [acs_pkg::BYTE_W-1:0]   req_char_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [acs_pkg::BYTE_W-1:0]   rsp_char_out,
   output logic                         rsp_invalid
);

   acs_pkg::acs_keys_type keys_ff, keys_in;
   logic                  wr_en;
   logic [1:0]            reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      keys_in = keys_ff;
      if (wr_en) begin
         case (reg_sel)
            acs_pkg::REG_KEY_MULT: begin
               keys_in.mult = csr_pwdata[acs_pkg::KEY_W-1:0];
            end
            acs_pkg::REG_KEY_ADD: begin
               keys_in.add = csr_pwdata[acs_pkg::KEY_W-1:0];
            end
            acs_pkg::REG_KEY_MULT_INV: begin
               keys_in.mult_inverse = csr_pwdata[acs_pkg::KEY_W-1:0];
            end
            default: begin
               keys_in = keys_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff.mult         <= acs_pkg::KEY_W'(1);
         keys_ff.add          <= '0;
         keys_ff.mult_inverse <= acs_pkg::KEY_W'(1);
      end else begin
         keys_ff <= keys_in;
      end
   end

   always_comb begin
      case (reg_sel)
         acs_pkg::REG_KEY_MULT: begin
            csr_prdata = acs_pkg::DATA_W'(keys_ff.mult);
         end
         acs_pkg::REG_KEY_ADD: begin
            csr_prdata = acs_pkg::DATA_W'(keys_ff.add);
         end
         acs_pkg::REG_KEY_MULT_INV: begin
            csr_prdata = acs_pkg::DATA_W'(keys_ff.mult_inverse);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   acs_xform u_xform (
      .clock        (clock),
      .reset        (reset),
      .keys         (keys_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_invalid  (rsp_invalid)
   );

endmodule

@@ rtl/core/acs_checker.sv @@
// port-level checks for the affine cipher, bound to the top level
`timescale 1ns / 1ps

module acs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [acs_pkg::BYTE_W-1:0]   rsp_char_out,
   input logic                         rsp_invalid
);

   // nothing comes out in the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // an empty result register means the whole pipeline can move
   a_no_stall_when_empty : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_valid) |-> !req_stall)
      else $error("input stalled while result side is empty");

   // only an out-of-alphabet byte gives a zero byte
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_invalid == (rsp_char_out == 8'h00)))
      else $error("invalid flag and zero byte disagree");

   // a stalled result word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_char_out) && $stable(rsp_invalid)))
      else $error("stalled result word changed");

endmodule

bind affine_cipher_66_symbol acs_checker u_acs_checker (.*);

@@ tb/tb_affine_cipher_66_symbol.sv @@
// self-checking testbench for the 66-symbol affine cipher: random and directed words, key sweeps
`timescale 1ns / 1ps

module tb_affine_cipher_66_symbol;

   localparam int NUM_SYMBOLS = 66;
   localparam logic [8*NUM_SYMBOLS-1:0] SYMBOLS =
      "abcdefghijklmnopqrstuvwxyz ABCDEFGHIJKLMNOPQRSTUVWXYZ.-_0123456789";
   localparam int UNMAPPED_REG = 3;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_WORDS = 210;

   typedef struct packed {
      logic                       op;
      logic [acs_pkg::BYTE_W-1:0] ch;
   } cipher_word_type;

   typedef struct packed {
      logic [acs_pkg::BYTE_W-1:0] char_out;
      logic                       invalid;
   } cipher_result_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [acs_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [acs_pkg::DATA_W-1:0] csr_pwdata = '0;
   logic [acs_pkg::DATA_W-1:0] csr_prdata;
   logic csr_pready;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [acs_pkg::BYTE_W-1:0] req_char_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [acs_pkg::BYTE_W-1:0] rsp_char_out;
   logic rsp_invalid;

   // model copy of the key registers
   logic [acs_pkg::KEY_W-1:0] key_mult = 7'd1;
   logic [acs_pkg::KEY_W-1:0] key_add = 7'd0;
   logic [acs_pkg::KEY_W-1:0] key_mult_inverse = 7'd1;

   cipher_word_type   pending_words[$];
   cipher_result_type expected_chars[$];
   int error_count = 0;
   int sender_idle_pct = 24;
   int receiver_idle_pct = 58;
   int chars_received = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   affine_cipher_66_symbol uut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_out(rsp_char_out),
      .rsp_invalid(rsp_invalid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [acs_pkg::BYTE_W-1:0] symbol_at(input int i);
      return SYMBOLS[8*(NUM_SYMBOLS-1-i) +: 8];
   endfunction

   function automatic cipher_result_type affine_map(input logic op,
                                                    input logic [acs_pkg::BYTE_W-1:0] ch);
      cipher_result_type r;
      int x;
      int b;
      int y;
      int i;
      x = -1;
      for (i = 0; i < NUM_SYMBOLS; i++) begin
         if (symbol_at(i) == ch) x = i;
      end
      if (x < 0) begin
         r.char_out = '0;
         r.invalid = 1'b1;
      end else begin
         b = int'(key_add) % NUM_SYMBOLS;
         if (acs_pkg::acs_op_type'(op) == acs_pkg::OP_ENCRYPT) begin
            y = (int'(key_mult) * x + b) % NUM_SYMBOLS;
         end else begin
            y = (int'(key_mult_inverse) * ((x + NUM_SYMBOLS - b) % NUM_SYMBOLS))
                % NUM_SYMBOLS;
         end
         r.char_out = symbol_at(y);
         r.invalid = 1'b0;
      end
      return r;
   endfunction

   // sender: offers queued words, holds a stalled word unchanged
   always @(posedge clock) begin : send_words
      cipher_word_type w;
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_chars.push_back(affine_map(req_op, req_char_in));
         end
         if (!(req_valid && req_stall)) begin
            offer = (pending_words.size() != 0) && ($urandom_range(0, 99) >= sender_idle_pct);
            if (offer) begin
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_op <= w.op;
               req_char_in <= w.ch;
            end else begin
               req_valid <= 1'b0;
               req_op <= 1'($urandom);
               req_char_in <= 8'($urandom);
            end
         end
      end
   end

   // receiver: checks each word against the oldest prediction, drives stall
   always @(posedge clock) begin : check_words
      cipher_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected word: char_out %h invalid %b", rsp_char_out, rsp_invalid);
            error_count++;
         end else begin
            e = expected_chars.pop_front();
            if (rsp_char_out !== e.char_out) begin
               $error("char_out: expected %h, got %h", e.char_out, rsp_char_out);
               error_count++;
            end
            if (rsp_invalid !== e.invalid) begin
               $error("invalid: expected %b, got %b", e.invalid, rsp_invalid);
               error_count++;
            end
         end
         chars_received++;
         // long hold-offs so the pipeline backs up into the input
         if (chars_received == 250 || chars_received == 1250) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_affine_cipher_66_symbol: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input int idx, input logic [acs_pkg::KEY_W-1:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= acs_pkg::ADDR_W'(4 * idx);
      // bits above the key width are don't-care
      csr_pwdata <= {25'($urandom), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == acs_pkg::REG_KEY_MULT) key_mult = val;
      else if (idx == acs_pkg::REG_KEY_ADD) key_add = val;
      else if (idx == acs_pkg::REG_KEY_MULT_INV) key_mult_inverse = val;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || expected_chars.size() != 0 || req_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_keys(input logic [acs_pkg::KEY_W-1:0] a,
                           input logic [acs_pkg::KEY_W-1:0] b,
                           input logic [acs_pkg::KEY_W-1:0] a_inv);
      cipher_word_type w;
      csr_write(acs_pkg::REG_KEY_MULT, a);
      csr_write(acs_pkg::REG_KEY_ADD, b);
      csr_write(acs_pkg::REG_KEY_MULT_INV, a_inv);
      @(negedge clock);
      repeat (PHASE_WORDS) begin
         w.op = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) < 7) w.ch = symbol_at($urandom_range(0, NUM_SYMBOLS - 1));
         else w.ch = 8'($urandom_range(0, 255));
         pending_words.push_back(w);
      end
      wait_drained();
   endtask

   initial begin : stimulus
      logic [acs_pkg::BYTE_W-1:0] directed[20];
      int i;
      int a;
      int a_inv;
      directed = '{8'h61, 8'h7a, 8'h20, 8'h41, 8'h5a, 8'h2e, 8'h2d, 8'h5f, 8'h30, 8'h39,
                   8'h00, 8'hff, 8'h60, 8'h7b, 8'h40, 8'h5b, 8'h2f, 8'h3a, 8'h21, 8'h80};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // reset keys give the identity map in both directions
      for (i = 0; i < 20; i++) begin
         pending_words.push_back('{op: 1'(i % 2), ch: directed[i]});
      end
      pending_words.push_back('{op: acs_pkg::OP_DECRYPT, ch: 8'h61});
      pending_words.push_back('{op: acs_pkg::OP_ENCRYPT, ch: 8'h39});
      wait_drained();

      run_keys(7'd5, 7'd3, 7'd53);
      run_keys(7'd127, 7'd127, 7'd127);
      run_keys(7'd0, 7'd0, 7'd0);

      sender_idle_pct = 58;
      receiver_idle_pct = 24;
      run_keys(7'd65, 7'd65, 7'd65);
      run_keys(7'd7, 7'd66, 7'd19);
      do a = $urandom_range(1, 65); while (a % 2 == 0 || a % 3 == 0 || a % 11 == 0);
      a_inv = 1;
      for (i = 1; i < NUM_SYMBOLS; i++) begin
         if ((a * i) % NUM_SYMBOLS == 1) a_inv = i;
      end
      run_keys(7'(a), 7'($urandom_range(0, 127)), 7'(a_inv));

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      run_keys(7'($urandom), 7'($urandom), 7'($urandom));
      // a write past the last register must leave the keys alone
      csr_write(UNMAPPED_REG, 7'($urandom));
      run_keys(7'd1, 7'd0, 7'd1);

      if (error_count == 0) begin
         $display("tb_affine_cipher_66_symbol: done, clean");
      end else begin
         $display("tb_affine_cipher_66_symbol: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/acs_pkg.sv
rtl/core/acs_xform.sv
rtl/core/affine_cipher_66_symbol.sv
rtl/core/acs_checker.sv
tb/tb_affine_cipher_66_symbol.sv
